// ===== sv/ipid_pkg.sv =====
package ipid_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS  = 20;
    localparam int ADC_W      = 12;
    localparam int VOLT_W     = 22;
    localparam int COEF_W     = 24;
    localparam int SCALE_W    = 16;
    localparam int PWM_W      = 16;
    localparam int ERR_W      = 24;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier: signed operands, one registered product
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = PROD_W - FRAC_BITS + 2;

    localparam logic [VOLT_W-1:0] VOLT_MAX = {VOLT_W{1'b1}};
    localparam logic [PWM_W-1:0]  PWM_MAX  = {PWM_W{1'b1}};

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_COEF_NOW   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_PREV  = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_PREV2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_VPC        = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRIVE_MAX  = 3'd4;
    localparam logic [IDX_W-1:0] REG_CPV        = 3'd5;

    // Multiplier operand selection
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_MEAS = 3'd0;
    localparam t_mul_sel MUL_E0   = 3'd1;
    localparam t_mul_sel MUL_E1   = 3'd2;
    localparam t_mul_sel MUL_E2   = 3'd3;
    localparam t_mul_sel MUL_PWM  = 3'd4;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_now;
        logic signed [COEF_W-1:0] coef_prev;
        logic signed [COEF_W-1:0] coef_prev2;
        logic [SCALE_W-1:0]       volts_per_code;
        logic [VOLT_W-1:0]        drive_max;
        logic [SCALE_W-1:0]       counts_per_volt;
    } t_cfg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     cap_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_first;
        logic     acc_add;
        logic     meas_en;
        logic     drive_en;
        logic     out_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic closed;
        logic out_busy;
    } t_stat;

endpackage

// ===== sv/ipid_if.sv =====
interface ipid_in_if;
    import ipid_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADC_W-1:0]  adc_sample;
    logic [VOLT_W-1:0] reference_volts;
    logic              closed_loop;

    modport source(output valid, adc_sample, reference_volts, closed_loop, input ready);
    modport sink(input valid, adc_sample, reference_volts, closed_loop, output ready);
endinterface

interface ipid_out_if;
    import ipid_pkg::*;

    logic              valid;
    logic              ready;
    logic [PWM_W-1:0]  pwm_compare;
    logic [VOLT_W-1:0] measured_volts;
    logic [VOLT_W-1:0] drive_volts;

    modport source(output valid, pwm_compare, measured_volts, drive_volts, input ready);
    modport sink(input valid, pwm_compare, measured_volts, drive_volts, output ready);
endinterface

interface ipid_cfg_if;
    import ipid_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [IDX_W-1:0]      index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/ipid_regs.sv =====
module ipid_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_valid,
    input  logic [ipid_pkg::IDX_W-1:0]      i_wr_index,
    input  logic [ipid_pkg::CFG_DATA_W-1:0] i_wr_data,
    output logic                            o_wr_ready,
    output ipid_pkg::t_cfg                  o_cfg
);
    import ipid_pkg::*;

    t_cfg r_cfg;

    // Writes are taken in every cycle.
    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    // Register file with reset values; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_now        <= 24'sd44040;
            r_cfg.coef_prev       <= -24'sd53477;
            r_cfg.coef_prev2      <= 24'sd26214;
            r_cfg.volts_per_code  <= 16'd845;
            r_cfg.drive_max       <= 22'd3460301;
            r_cfg.counts_per_volt <= 16'd7575;
        end else if (i_wr_valid) begin
            case (i_wr_index)
                REG_COEF_NOW:   r_cfg.coef_now        <= i_wr_data[COEF_W-1:0];
                REG_COEF_PREV:  r_cfg.coef_prev       <= i_wr_data[COEF_W-1:0];
                REG_COEF_PREV2: r_cfg.coef_prev2      <= i_wr_data[COEF_W-1:0];
                REG_VPC:        r_cfg.volts_per_code  <= i_wr_data[SCALE_W-1:0];
                REG_DRIVE_MAX:  r_cfg.drive_max       <= i_wr_data[VOLT_W-1:0];
                REG_CPV:        r_cfg.counts_per_volt <= i_wr_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/ipid_ctrl.sv =====
module ipid_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ipid_pkg::t_stat i_stat,
    output ipid_pkg::t_cmd  o_cmd
);
    import ipid_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MMEAS = 4'd1;
    localparam logic [3:0] ST_MEAS  = 4'd2;
    localparam logic [3:0] ST_M0    = 4'd3;
    localparam logic [3:0] ST_M1    = 4'd4;
    localparam logic [3:0] ST_M2    = 4'd5;
    localparam logic [3:0] ST_SUM   = 4'd6;
    localparam logic [3:0] ST_DRIVE = 4'd7;
    localparam logic [3:0] ST_MPWM  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    // Sequencer: one multiply per step, accumulate on the following step.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_MEAS;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = ST_MMEAS;
                end
            end
            ST_MMEAS: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MEAS;
                n_state       = ST_MEAS;
            end
            ST_MEAS: begin
                o_cmd.meas_en = 1'b1;
                n_state       = i_stat.closed ? ST_M0 : ST_MPWM;
            end
            ST_M0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_E0;
                n_state       = ST_M1;
            end
            ST_M1: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MUL_E1;
                o_cmd.acc_first = 1'b1;
                n_state         = ST_M2;
            end
            ST_M2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_E2;
                o_cmd.acc_add = 1'b1;
                n_state       = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_DRIVE;
            end
            ST_DRIVE: begin
                o_cmd.drive_en = 1'b1;
                n_state        = ST_MPWM;
            end
            ST_MPWM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PWM;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                // Wait here while the previous result is still unclaimed.
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/ipid_dp.sv =====
module ipid_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ipid_pkg::t_cmd              i_cmd,
    input  ipid_pkg::t_cfg              i_cfg,
    input  logic [ipid_pkg::ADC_W-1:0]  i_adc_sample,
    input  logic [ipid_pkg::VOLT_W-1:0] i_reference_volts,
    input  logic                        i_closed_loop,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [ipid_pkg::PWM_W-1:0]  o_pwm_compare,
    output logic [ipid_pkg::VOLT_W-1:0] o_measured_volts,
    output logic [ipid_pkg::VOLT_W-1:0] o_drive_volts,
    output ipid_pkg::t_stat             o_stat
);
    import ipid_pkg::*;

    // Captured request
    logic [ADC_W-1:0]  r_adc;
    logic [VOLT_W-1:0] r_ref;
    logic              r_closed;

    // Working registers
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic [VOLT_W-1:0]        r_meas;
    logic signed [ERR_W-1:0]  r_err;
    logic [VOLT_W-1:0]        r_drive;

    // Loop state
    logic [VOLT_W-1:0]       r_last_drive;
    logic signed [ERR_W-1:0] r_err_prev;
    logic signed [ERR_W-1:0] r_err_prev2;

    // Result register
    logic              r_out_valid;
    logic [PWM_W-1:0]  r_pwm;
    logic [VOLT_W-1:0] r_out_meas;
    logic [VOLT_W-1:0] r_out_drive;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic [VOLT_W-1:0]        meas_sat;
    logic signed [SUM_W-1:0]  drive_sum;
    logic [VOLT_W-1:0]        drive_clamped;
    logic [PWM_W-1:0]         pwm_sat;

    assign o_stat.closed   = r_closed;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_pwm_compare    = r_pwm;
    assign o_measured_volts = r_out_meas;
    assign o_drive_volts    = r_out_drive;

    // Operand selection for the shared signed multiplier.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_MEAS: begin
                mul_a = MUL_W'(signed'({1'b0, r_adc}));
                mul_b = MUL_W'(signed'({1'b0, i_cfg.volts_per_code}));
            end
            MUL_E0: begin
                mul_a = MUL_W'(i_cfg.coef_now);
                mul_b = MUL_W'(r_err);
            end
            MUL_E1: begin
                mul_a = MUL_W'(i_cfg.coef_prev);
                mul_b = MUL_W'(r_err_prev);
            end
            MUL_E2: begin
                mul_a = MUL_W'(i_cfg.coef_prev2);
                mul_b = MUL_W'(r_err_prev2);
            end
            MUL_PWM: begin
                mul_a = MUL_W'(signed'({1'b0, r_drive}));
                mul_b = MUL_W'(signed'({1'b0, i_cfg.counts_per_volt}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Measured voltage saturates at the top of its field.
    assign meas_sat = (r_prod[PROD_W-1:VOLT_W] != '0) ? VOLT_MAX : r_prod[VOLT_W-1:0];

    // New drive: previous drive plus the floored sum, clamped to 0..drive_max.
    assign drive_sum = SUM_W'(signed'(r_acc[PROD_W-1:FRAC_BITS]))
                     + SUM_W'(signed'({1'b0, r_last_drive}));

    always_comb begin
        if (drive_sum < 0) begin
            drive_clamped = '0;
        end else if (drive_sum > SUM_W'(signed'({1'b0, i_cfg.drive_max}))) begin
            drive_clamped = i_cfg.drive_max;
        end else begin
            drive_clamped = drive_sum[VOLT_W-1:0];
        end
    end

    // Compare level: product scaled down, saturated at full scale.
    assign pwm_sat = (r_prod[PROD_W-1:FRAC_BITS+PWM_W] != '0) ? PWM_MAX
                   : r_prod[FRAC_BITS+PWM_W-1:FRAC_BITS];

    // Working path, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_adc    <= i_adc_sample;
            r_ref    <= i_reference_volts;
            r_closed <= i_closed_loop;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc_first) begin
            r_acc <= r_prod;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.meas_en) begin
            r_meas <= meas_sat;
            r_err  <= ERR_W'(signed'({1'b0, r_ref})) - ERR_W'(signed'({1'b0, meas_sat}));
            if (!r_closed) begin
                r_drive <= r_ref;
            end
        end
        if (i_cmd.drive_en) begin
            r_drive <= drive_clamped;
        end
        if (i_cmd.out_load) begin
            r_pwm       <= pwm_sat;
            r_out_meas  <= r_meas;
            r_out_drive <= r_drive;
        end
    end

    // Loop state and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_drive <= '0;
            r_err_prev   <= '0;
            r_err_prev2  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.drive_en) begin
                r_err_prev2 <= r_err_prev;
                r_err_prev  <= r_err;
            end
            if (i_cmd.out_load) begin
                r_last_drive <= r_drive;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/incremental_pid_step.sv =====
// Incremental PID step: one drive update per sample request.
// i_in carries a 12-bit converter code, the setpoint voltage and the
// closed-loop flag; o_out returns the PWM compare level, the measured
// voltage and the drive voltage; i_cfg writes the six control registers
// by index (writes are taken in every cycle; the user must write them
// only while the block is idle; the block itself does not enforce this).
// All arithmetic goes through one shared 25x25 signed multiplier with a
// registered product, run by a small sequencer. In closed loop a request
// is scaled, three error terms are multiplied and accumulated, the new
// drive is clamped and scaled to PWM counts; in open loop the setpoint
// is taken as the drive. A request is taken only while the sequencer is
// idle, so no new request is taken before the last one is finished; the
// next one can be taken while a result still waits in the output register.
// If the receiver stalls, the sequencer holds its finished result at the
// final step until the output register frees up.
// Reset clears the drive and error history, loads the default control
// registers and empties the output register.
module incremental_pid_step (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ipid_in_if.sink     i_in,
    ipid_out_if.source  o_out,
    ipid_cfg_if.sink    i_cfg
);
    import ipid_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    ipid_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (cfg)
    );

    ipid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ipid_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg             (cfg),
        .i_adc_sample      (i_in.adc_sample),
        .i_reference_volts (i_in.reference_volts),
        .i_closed_loop     (i_in.closed_loop),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_pwm_compare     (o_out.pwm_compare),
        .o_measured_volts  (o_out.measured_volts),
        .o_drive_volts     (o_out.drive_volts),
        .o_stat            (stat)
    );

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_out.valid && !o_out.ready))
        else $error("result loaded over a pending result");

    // Loading a result always presents it on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out.valid)
        else $error("loaded result not presented");

    // Once a request is taken, no second one is taken until it is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while another is in progress");

    // Capture, scaling, drive update and result load are separate steps.
    a_steps_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.cap_in, cmd.meas_en, cmd.drive_en, cmd.out_load}))
        else $error("sequencer steps overlap");

endmodule
